[design/sparse_polynomial_add_defines.svh]
// Assertion macros for the sparse polynomial adder.
// Used by the top level; no other dependencies.
`ifndef SPARSE_POLYNOMIAL_ADD_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADD_DEFINES_SVH

// same-cycle implication
`define SPA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/spa_pkg.sv]
// Shared types and constants for the sparse polynomial adder.
// No dependencies.
package spa_pkg;

  localparam int MAX_TERMS = 16;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int COEF_W    = 16;
  localparam int SUM_W     = COEF_W + 1;
  localparam int EXP_W     = 8;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MERGE  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [COEF_W-1:0]  coefficient;
    logic        [EXP_W-1:0]   exponent;
  } in_beat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   sum_coefficient;
    logic        [EXP_W-1:0]   term_exponent;
    logic                      empty_res;
    logic                      dropped;
    logic                      last;
  } out_beat_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coefficient;
    logic        [EXP_W-1:0]   exponent;
  } term_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    term_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic emit;
    logic last;
  } spa_status_t;

endpackage

[design/sparse_polynomial_add.sv]
// Loads: one beat per cycle, no result. Merge: the term stores register the read data, then
// one result per cycle enters the result register while the output is not stalled (two
// term-store read ports, read pointers prefetched); the next beat waits for the last result.
// Result register decouples output stall; loads are taken while a result waits.
// Synchronous active-high reset clears counts, overflow flag and control;
// term stores are not cleared (only entries below the counts are read).
module sparse_polynomial_add (
  input  logic               clk,
  input  logic               rst,
  input  logic               term_valid,
  output logic               term_stall,
  input  spa_pkg::in_beat_t  term,
  output logic               result_valid,
  input  logic               result_stall,
  output spa_pkg::out_beat_t result
);

  `include "sparse_polynomial_add_defines.svh"

  spa_pkg::ram_wr_t          a_wr, b_wr;
  logic [spa_pkg::IDX_W-1:0] a_rd_addr, b_rd_addr;
  spa_pkg::term_t            a_rd_data, b_rd_data;
  spa_pkg::spa_status_t      status;

  spa_term_ram u_ram_a (
    .clk     (clk),
    .wr      (a_wr),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  spa_term_ram u_ram_b (
    .clk     (clk),
    .wr      (b_wr),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  spa_merge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (term_valid),
    .in_stall  (term_stall),
    .in_data   (term),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result),
    .a_wr      (a_wr),
    .b_wr      (b_wr),
    .a_rd_addr (a_rd_addr),
    .b_rd_addr (b_rd_addr),
    .a_rd_data (a_rd_data),
    .b_rd_data (b_rd_data),
    .status    (status)
  );

  `SPA_ASSERT_NOW(a_empty_is_last, clk, rst, result_valid && result.empty_res, result.last, "empty result not flagged last")
  `SPA_ASSERT_NOW(a_no_overwrite, clk, rst, status.emit, !(result_valid && result_stall), "result overwritten while stalled")
  `SPA_ASSERT_NEXT(a_last_frees_input, clk, rst, status.emit && status.last, !term_stall, "input still stalled after final result")
  `SPA_ASSERT_NEXT(a_merge_busy, clk, rst, term_valid && !term_stall && (term.operation == spa_pkg::OP_MERGE), term_stall, "merge beat did not occupy the block")

endmodule

[design/spa_term_ram.sv]
// Term store: one write port, one registered read port.
// Depends on spa_pkg.
module spa_term_ram (
  input  logic                     clk,
  input  spa_pkg::ram_wr_t         wr,
  input  logic [spa_pkg::IDX_W-1:0] rd_addr,
  output spa_pkg::term_t           rd_data
);

  spa_pkg::term_t mem [spa_pkg::MAX_TERMS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/spa_merge_ctrl.sv]
// Load/merge sequencer: term counts, merge read pointers, result register.
// Depends on spa_pkg; drives two spa_term_ram instances.
module spa_merge_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  spa_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output spa_pkg::out_beat_t        out_data,
  output spa_pkg::ram_wr_t          a_wr,
  output spa_pkg::ram_wr_t          b_wr,
  output logic [spa_pkg::IDX_W-1:0] a_rd_addr,
  output logic [spa_pkg::IDX_W-1:0] b_rd_addr,
  input  spa_pkg::term_t            a_rd_data,
  input  spa_pkg::term_t            b_rd_data,
  output spa_pkg::spa_status_t      status
);

  typedef enum logic {S_IDLE, S_MERGE} state_t;

  state_t                    state;
  logic [spa_pkg::CNT_W-1:0] cnt_a, cnt_b, ptr_a, ptr_b;
  logic [spa_pkg::CNT_W-1:0] ptr_a_next, ptr_b_next;
  logic                      ovf;

  logic accept, a_left, b_left, take_a, take_b, out_free, emit, done;
  logic signed [spa_pkg::SUM_W-1:0] coef_a, coef_b;
  spa_pkg::out_beat_t res_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    a_wr.en   = accept && (in_data.operation == spa_pkg::OP_LOAD_A) &&
                (cnt_a < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS));
    a_wr.addr = cnt_a[spa_pkg::IDX_W-1:0];
    a_wr.data = {in_data.coefficient, in_data.exponent};
    b_wr.en   = accept && (in_data.operation == spa_pkg::OP_LOAD_B) &&
                (cnt_b < spa_pkg::CNT_W'(spa_pkg::MAX_TERMS));
    b_wr.addr = cnt_b[spa_pkg::IDX_W-1:0];
    b_wr.data = {in_data.coefficient, in_data.exponent};
  end

  // merge step: equal exponents take both
  assign a_left   = (ptr_a < cnt_a);
  assign b_left   = (ptr_b < cnt_b);
  assign take_a   = a_left && (!b_left || (a_rd_data.exponent >= b_rd_data.exponent));
  assign take_b   = b_left && (!a_left || (b_rd_data.exponent >= a_rd_data.exponent));
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == S_MERGE) && out_free;

  assign coef_a = take_a ? {a_rd_data.coefficient[spa_pkg::COEF_W-1], a_rd_data.coefficient}
                         : '0;
  assign coef_b = take_b ? {b_rd_data.coefficient[spa_pkg::COEF_W-1], b_rd_data.coefficient}
                         : '0;

  always_comb begin
    ptr_a_next = ptr_a;
    ptr_b_next = ptr_b;
    if (accept && (in_data.operation == spa_pkg::OP_MERGE)) begin
      ptr_a_next = '0;
      ptr_b_next = '0;
    end else if (emit) begin
      ptr_a_next = ptr_a + spa_pkg::CNT_W'(take_a);
      ptr_b_next = ptr_b + spa_pkg::CNT_W'(take_b);
    end
  end

  assign done      = !(ptr_a_next < cnt_a) && !(ptr_b_next < cnt_b);
  assign a_rd_addr = ptr_a_next[spa_pkg::IDX_W-1:0];
  assign b_rd_addr = ptr_b_next[spa_pkg::IDX_W-1:0];

  always_comb begin
    res_next.sum_coefficient = coef_a + coef_b;
    res_next.term_exponent   = take_a ? a_rd_data.exponent :
                               (take_b ? b_rd_data.exponent : '0);
    res_next.empty_res       = !a_left && !b_left;
    res_next.dropped         = ovf;
    res_next.last            = done;
  end

  assign status.emit = emit;
  assign status.last = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      ptr_a     <= '0;
      ptr_b     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      ptr_a <= ptr_a_next;
      ptr_b <= ptr_b_next;
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= res_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.operation)
              spa_pkg::OP_LOAD_A: begin
                if (a_wr.en) cnt_a <= cnt_a + spa_pkg::CNT_W'(1);
                else         ovf   <= 1'b1;
              end
              spa_pkg::OP_LOAD_B: begin
                if (b_wr.en) cnt_b <= cnt_b + spa_pkg::CNT_W'(1);
                else         ovf   <= 1'b1;
              end
              spa_pkg::OP_MERGE: state <= S_MERGE;
              default: ;
            endcase
          end
        end
        S_MERGE: begin
          if (emit && done) begin
            state <= S_IDLE;
            cnt_a <= '0;
            cnt_b <= '0;
            ovf   <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for sparse_polynomial_add: streams pairs of sparse polynomials plus merge beats and
// checks every emitted term against an in-bench merge predictor, with random idle on both sides.
// Depends on spa_pkg and the sparse_polynomial_add RTL.
module tb;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               term_valid = 1'b0;
  logic               term_stall;
  spa_pkg::in_beat_t  term = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  spa_pkg::out_beat_t result;

  sparse_polynomial_add DUT (
    .clk          (clk),
    .rst          (rst),
    .term_valid   (term_valid),
    .term_stall   (term_stall),
    .term         (term),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  spa_pkg::in_beat_t  pending[$];
  spa_pkg::out_beat_t sum_terms_q[$];
  spa_pkg::term_t     poly_a [spa_pkg::MAX_TERMS];
  spa_pkg::term_t     poly_b [spa_pkg::MAX_TERMS];
  int                 count_a = 0;
  int                 count_b = 0;
  logic               lost_term = 1'b0;
  int                 errors = 0;
  logic               term_taken = 1'b0;
  int                 send_gap = 0;
  int                 stall_left = 0;
  spa_pkg::out_beat_t want;

  initial forever #5 clk = ~clk;

  function automatic spa_pkg::in_beat_t term_beat(spa_pkg::op_t op, int coef, int expo);
    spa_pkg::in_beat_t b;
    b.operation   = op;
    b.coefficient = coef[spa_pkg::COEF_W-1:0];
    b.exponent    = expo[spa_pkg::EXP_W-1:0];
    return b;
  endfunction

  function automatic int rand_coef();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 1) ? 32767 : -32768;
    end
    return $urandom;
  endfunction

  // Merge predictor: loads fill the term lists, a merge walks both by exponent.
  task automatic apply_term(input spa_pkg::in_beat_t b);
    int                 i;
    int                 j;
    logic               held;
    spa_pkg::out_beat_t cur;
    spa_pkg::out_beat_t nxt;
    i = 0;
    j = 0;
    held = 1'b0;
    cur = '0;
    nxt = '0;
    case (b.operation)
      spa_pkg::OP_LOAD_A: begin
        if (count_a < spa_pkg::MAX_TERMS) begin
          poly_a[count_a] = {b.coefficient, b.exponent};
          count_a++;
        end else begin
          lost_term = 1'b1;
        end
      end
      spa_pkg::OP_LOAD_B: begin
        if (count_b < spa_pkg::MAX_TERMS) begin
          poly_b[count_b] = {b.coefficient, b.exponent};
          count_b++;
        end else begin
          lost_term = 1'b1;
        end
      end
      spa_pkg::OP_MERGE: begin
        nxt.dropped = lost_term;
        if (count_a == 0 && count_b == 0) begin
          nxt.empty_res = 1'b1;
          cur = nxt;
        end
        while (i < count_a || j < count_b) begin
          if (j >= count_b || (i < count_a && poly_a[i].exponent > poly_b[j].exponent)) begin
            nxt.sum_coefficient = {poly_a[i].coefficient[spa_pkg::COEF_W-1],
                                   poly_a[i].coefficient};
            nxt.term_exponent   = poly_a[i].exponent;
            i++;
          end else if (i >= count_a || poly_b[j].exponent > poly_a[i].exponent) begin
            nxt.sum_coefficient = {poly_b[j].coefficient[spa_pkg::COEF_W-1],
                                   poly_b[j].coefficient};
            nxt.term_exponent   = poly_b[j].exponent;
            j++;
          end else begin
            nxt.sum_coefficient = {poly_a[i].coefficient[spa_pkg::COEF_W-1],
                                   poly_a[i].coefficient}
                                + {poly_b[j].coefficient[spa_pkg::COEF_W-1],
                                   poly_b[j].coefficient};
            nxt.term_exponent   = poly_a[i].exponent;
            i++;
            j++;
          end
          if (held) begin
            sum_terms_q.push_back(cur);
          end
          cur = nxt;
          held = 1'b1;
        end
        cur.last = 1'b1;
        sum_terms_q.push_back(cur);
        count_a = 0;
        count_b = 0;
        lost_term = 1'b0;
      end
      default: ;
    endcase
  endtask

  // One random polynomial pair, loads interleaved, then a merge.
  task automatic queue_poly_pair();
    spa_pkg::in_beat_t la[$];
    spa_pkg::in_beat_t lb[$];
    int                n_a;
    int                n_b;
    int                shape;
    int                step_max;
    int                cur_e;
    int                k;
    shape = $urandom_range(0, 5);
    step_max = $urandom_range(0, 1) ? 2 : 14;
    n_a = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 8);
    n_b = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(0, 8);
    if (shape == 1) begin
      n_b = n_a;
    end
    cur_e = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
    for (k = 0; k < n_a; k++) begin
      la.push_back(term_beat(spa_pkg::OP_LOAD_A, rand_coef(),
                             shape == 0 ? $urandom_range(0, 255) : cur_e));
      cur_e -= $urandom_range(1, step_max);
      if (cur_e < 0) cur_e = 0;
    end
    cur_e = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 255);
    for (k = 0; k < n_b; k++) begin
      if (shape == 1) begin
        lb.push_back(term_beat(spa_pkg::OP_LOAD_B,
                               $urandom_range(0, 1) ? -int'(la[k].coefficient) : rand_coef(),
                               la[k].exponent));
      end else begin
        lb.push_back(term_beat(spa_pkg::OP_LOAD_B, rand_coef(),
                               shape == 0 ? $urandom_range(0, 255) : cur_e));
        cur_e -= $urandom_range(1, step_max);
        if (cur_e < 0) cur_e = 0;
      end
    end
    while (la.size() + lb.size() > 0) begin
      if (lb.size() == 0 || (la.size() != 0 && $urandom_range(0, 1))) begin
        pending.push_back(la.pop_front());
      end else begin
        pending.push_back(lb.pop_front());
      end
      if ($urandom_range(0, 19) == 0) begin
        pending.push_back(term_beat(spa_pkg::OP_NOP, $urandom, $urandom));
      end
    end
    pending.push_back(term_beat(spa_pkg::OP_MERGE, $urandom, $urandom));
  endtask

  initial begin
    // both lists empty
    pending.push_back(term_beat(spa_pkg::OP_MERGE, 0, 0));
    // coefficient and exponent extremes, equal-exponent and B-only merge branches
    pending.push_back(term_beat(spa_pkg::OP_LOAD_A, 32767, 255));
    pending.push_back(term_beat(spa_pkg::OP_LOAD_A, -32768, 0));
    pending.push_back(term_beat(spa_pkg::OP_LOAD_B, 32767, 255));
    pending.push_back(term_beat(spa_pkg::OP_LOAD_B, -32768, 128));
    pending.push_back(term_beat(spa_pkg::OP_LOAD_B, -32768, 0));
    pending.push_back(term_beat(spa_pkg::OP_MERGE, 0, 0));
    // zero sum, ignored opcode
    pending.push_back(term_beat(spa_pkg::OP_LOAD_A, 5, 10));
    pending.push_back(term_beat(spa_pkg::OP_LOAD_B, -5, 10));
    pending.push_back(term_beat(spa_pkg::OP_NOP, -1, 255));
    pending.push_back(term_beat(spa_pkg::OP_MERGE, -1, 255));
    // one list only
    pending.push_back(term_beat(spa_pkg::OP_LOAD_B, 1, 3));
    pending.push_back(term_beat(spa_pkg::OP_MERGE, 0, 0));
    pending.push_back(term_beat(spa_pkg::OP_LOAD_A, 7, 200));
    pending.push_back(term_beat(spa_pkg::OP_MERGE, 0, 0));
    // lists out of order
    pending.push_back(term_beat(spa_pkg::OP_LOAD_A, 1, 1));
    pending.push_back(term_beat(spa_pkg::OP_LOAD_A, 2, 9));
    pending.push_back(term_beat(spa_pkg::OP_LOAD_B, 3, 5));
    pending.push_back(term_beat(spa_pkg::OP_MERGE, 0, 0));
    while (pending.size() < 225) begin
      queue_poly_pair();
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || term_valid) @(posedge clk);
    while (sum_terms_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // term driver
  always @(negedge clk) begin
    if (!rst && !(term_valid && !term_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        term_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        term <= pending.pop_front();
        term_valid <= 1'b1;
        if (pending.size() > 30 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 14);
        end
      end else begin
        term_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (pending.size() > 30 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
    end
  end

  // monitor: check results, then predict from the accepted input beat
  always @(posedge clk) begin
    term_taken <= term_valid && !term_stall;
    if (!rst && result_valid && !result_stall) begin
      if (sum_terms_q.size() == 0) begin
        $display("%0t: unexpected result coef %0d exp %0d empty %0b dropped %0b last %0b",
                 $time, result.sum_coefficient, result.term_exponent, result.empty_res,
                 result.dropped, result.last);
        errors++;
      end else begin
        want = sum_terms_q.pop_front();
        if (result.sum_coefficient !== want.sum_coefficient ||
            result.term_exponent !== want.term_exponent ||
            result.empty_res !== want.empty_res ||
            result.dropped !== want.dropped ||
            result.last !== want.last) begin
          $display("%0t: result wrong: expected coef %0d exp %0d empty %0b dropped %0b last %0b",
                   $time, want.sum_coefficient, want.term_exponent, want.empty_res,
                   want.dropped, want.last);
          $display("%0t:               actual coef %0d exp %0d empty %0b dropped %0b last %0b",
                   $time, result.sum_coefficient, result.term_exponent, result.empty_res,
                   result.dropped, result.last);
          errors++;
        end
      end
    end
    if (!rst && term_valid && !term_stall) begin
      apply_term(term);
    end
  end

endmodule

[files.f]
+incdir+design
design/spa_pkg.sv
design/spa_term_ram.sv
design/spa_merge_ctrl.sv
design/sparse_polynomial_add.sv
dv/tb.sv
